### sv/ppbt_pkg.sv
// Shared types, constants and a helper function of the page presence bitmap tracker.
package ppbt_pkg;

    localparam int unsigned LEN_BITS          = 33;
    localparam int unsigned ADDR_IN_BITS      = 64;
    localparam int unsigned WORD_BITS         = 64;
    localparam int unsigned BIT_IDX_BITS      = 6;
    localparam int unsigned CFG_BITS          = 6;
    localparam int unsigned MIN_WINDOW_BITS   = 20;
    localparam int unsigned RESET_WINDOW_BITS = 32;

    typedef enum logic [1:0] {
        FUNC_MARK  = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_PROBE = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // Control of the bitmap memory port
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

    // Position of the lowest set bit of a bitmap word
    function automatic logic [BIT_IDX_BITS-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_IDX_BITS-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_IDX_BITS'(i);
            end
        end
        return pos;
    endfunction

endpackage

### sv/ppbt_mem.sv
// Bitmap word store: one synchronous port, registered read data.
module ppbt_mem
    import ppbt_pkg::*;
#(
    parameter int unsigned DEPTH    = 4096,
    parameter int unsigned IDX_BITS = 12
) (
    input  logic                 i_clk,
    input  t_mem_ctl             i_ctl,
    input  logic [IDX_BITS-1:0]  i_addr,
    input  logic [WORD_BITS-1:0] i_wdata,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    // Write and read the addressed word
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ppbt_seq.sv
// Sequencer: clearing pass, word walk with read-modify-write, probe scan and result register.
module ppbt_seq
    import ppbt_pkg::*;
#(
    parameter int unsigned MAX_WINDOW_BITS = 32,
    parameter int unsigned PAGE_SHIFT      = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [MAX_WINDOW_BITS-1:0] i_mask,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_func,
    input  logic [ADDR_IN_BITS-1:0]    i_guest_address,
    input  logic [LEN_BITS-1:0]        i_byte_length,
    output logic                       o_done,
    output logic [LEN_BITS-1:0]        o_mapped_bytes,
    output logic                       o_whole_range_mapped
);

    localparam int unsigned AW    = MAX_WINDOW_BITS;
    localparam int unsigned PW    = AW - PAGE_SHIFT;
    localparam int unsigned DEPTH = (PW >= BIT_IDX_BITS) ? (2 ** (PW - BIT_IDX_BITS)) : 1;
    localparam int unsigned WIW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW    = ((AW > LEN_BITS) ? AW : LEN_BITS) + 1;
    localparam int unsigned CW    = AW + 1;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_READ  = 6'b001000,
        ST_MOD   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [WIW-1:0]        r_w, n_w;
    logic                  r_done;
    t_func                 r_func;
    logic [AW-1:0]         r_a;
    logic [AW-1:0]         r_end;
    logic [LEN_BITS-1:0]   r_len;
    logic [WIW-1:0]        r_w0, r_w1;
    logic [BIT_IDX_BITS-1:0] r_lo, r_hi;
    logic                  r_found;
    logic [PW-1:0]         r_absent;
    logic [LEN_BITS-1:0]   r_mapped;
    logic                  r_whole;

    logic                  accept;
    logic [SW-1:0]         end_sum;
    logic [AW-1:0]         end_clip;
    logic [PW-1:0]         first_page, last_page;
    logic [BIT_IDX_BITS-1:0] lo, hi;
    logic [WORD_BITS-1:0]  word_mask, rdata, wdata, zero_bits;
    logic                  is_set_op, last_word;
    logic [AW-1:0]         absent_addr;
    logic [CW-1:0]         gap;
    logic [LEN_BITS-1:0]   mapped;
    logic [LEN_BITS-1:0]   n_mapped;
    logic                  n_whole;
    t_mem_ctl              mem_ctl;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Clip the range end to the window top and find its pages
    assign end_sum    = SW'(r_a) + SW'(r_len) - SW'(1);
    assign end_clip   = (end_sum > SW'(i_mask)) ? i_mask : AW'(end_sum);
    assign first_page = r_a[AW-1:PAGE_SHIFT];
    assign last_page  = end_clip[AW-1:PAGE_SHIFT];

    // Page bits of the current word that the range covers
    assign lo        = (r_w == r_w0) ? r_lo : '0;
    assign hi        = (r_w == r_w1) ? r_hi : '1;
    assign word_mask = ({WORD_BITS{1'b1}} >> (6'd63 - hi)) & ({WORD_BITS{1'b1}} << lo);
    assign is_set_op = (r_func == FUNC_MARK) || (r_func == FUNC_CLEAR);
    assign wdata     = (r_func == FUNC_MARK) ? (rdata | word_mask) : (rdata & ~word_mask);
    assign zero_bits = ~rdata & word_mask;
    assign last_word = (r_w == r_w1);

    // Mapped bytes: up to the first absent page (none if it is the first page),
    // or the whole clipped range
    assign absent_addr = {r_absent, {PAGE_SHIFT{1'b0}}};
    assign gap    = r_found ? ((absent_addr > r_a) ? (CW'(absent_addr) - CW'(r_a)) : CW'(0))
                            : (CW'(r_end) - CW'(r_a) + CW'(1));
    assign mapped = LEN_BITS'(gap);

    always_comb begin
        n_mapped = '0;
        n_whole  = 1'b0;
        if (r_func == FUNC_PROBE) begin
            if (r_len == '0) begin
                n_whole = 1'b1;
            end else begin
                n_mapped = mapped;
                n_whole  = (mapped == r_len);
            end
        end
    end

    // Memory port control
    always_comb begin
        mem_ctl.rd = (r_state == ST_READ);
        mem_ctl.wr = (r_state == ST_CLEAR) || ((r_state == ST_MOD) && is_set_op);
    end

    ppbt_mem #(
        .DEPTH    (DEPTH),
        .IDX_BITS (WIW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (r_w),
        .i_wdata ((r_state == ST_CLEAR) ? {WORD_BITS{1'b0}} : wdata),
        .o_rdata (rdata)
    );

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        n_w     = r_w;
        unique case (r_state)
            ST_CLEAR: begin
                n_w = r_w + WIW'(1);
                if (r_w == WIW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_w = WIW'(first_page >> BIT_IDX_BITS);
                if ((r_len == '0) || (r_func == FUNC_NONE)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_MOD;
            end
            ST_MOD: begin
                if (last_word || ((r_func == FUNC_PROBE) && (zero_bits != '0))) begin
                    n_state = ST_DONE;
                end else begin
                    n_w     = r_w + WIW'(1);
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_w     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_w     <= n_w;
            r_done  <= (r_state == ST_DONE);
        end
    end

    // Capture the transaction, the range bounds, the scan result and the output
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_func);
            r_a    <= i_guest_address[AW-1:0] & i_mask;
            r_len  <= i_byte_length;
        end
        if (r_state == ST_SETUP) begin
            r_end   <= end_clip;
            r_w0    <= WIW'(first_page >> BIT_IDX_BITS);
            r_w1    <= WIW'(last_page >> BIT_IDX_BITS);
            r_lo    <= BIT_IDX_BITS'(first_page);
            r_hi    <= BIT_IDX_BITS'(last_page);
            r_found <= 1'b0;
        end
        if ((r_state == ST_MOD) && (r_func == FUNC_PROBE) && (zero_bits != '0)) begin
            r_found  <= 1'b1;
            r_absent <= PW'({r_w, lowest_set(zero_bits)});
        end
        if (r_state == ST_DONE) begin
            r_mapped <= n_mapped;
            r_whole  <= n_whole;
        end
    end

    assign o_done               = r_done;
    assign o_mapped_bytes       = r_mapped;
    assign o_whole_range_mapped = r_whole;

endmodule

### sv/page_presence_bitmap_tracker_top.sv
// Top level of the page presence bitmap tracker: window register, sequencer and checks.
//
// Keeps one presence bit per 2^PAGE_SHIFT byte page of a guest window of up to
// 2^MAX_WINDOW_BITS bytes, stored as 64-bit words in a single-port memory.
// Command channel: a transaction is taken when start is high and busy is low.
// i_func 0 marks the pages a range touches, 1 clears them, 2 probes how many
// contiguous bytes from the address are mapped; 3 does nothing.
// Each transaction yields one result, shown for exactly one cycle with o_done.
// The receiver cannot stall; the result register frees the sequencer, which
// takes the next transaction in the same cycle that o_done is high.
// Sequence: a setup state, then a read state and a modify state for each bitmap
// word the range covers (a probe stops at the first absent page), then a result
// state; a zero-length range or i_func 3 goes from setup straight to result.
// Busy stays high through the result state, so each transaction waits for the last.
// Configuration channel: i_cfg_data (window bits) is written whenever
// i_cfg_valid is high; o_cfg_ready is always high. Write it only while idle.
// Reset: the window register returns to 32 bits (at most MAX_WINDOW_BITS) and a
// clearing pass zeroes every bitmap word, one per cycle (4096 words at the
// default parameters), with busy high throughout.
module page_presence_bitmap_tracker_top
    import ppbt_pkg::*;
#(
    parameter int unsigned MAX_WINDOW_BITS = 32,
    parameter int unsigned PAGE_SHIFT      = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_func,
    input  logic [ADDR_IN_BITS-1:0] i_guest_address,
    input  logic [LEN_BITS-1:0]     i_byte_length,
    output logic                    o_done,
    output logic [LEN_BITS-1:0]     o_mapped_bytes,
    output logic                    o_whole_range_mapped,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    localparam int unsigned AW = MAX_WINDOW_BITS;
    localparam int unsigned RESET_SAT =
        (RESET_WINDOW_BITS < MIN_WINDOW_BITS) ? MIN_WINDOW_BITS :
        (RESET_WINDOW_BITS > AW)              ? AW : RESET_WINDOW_BITS;
    localparam logic [AW:0] RESET_MASK_WIDE = ((AW + 1)'(1) << RESET_SAT) - (AW + 1)'(1);

    logic [AW-1:0]       r_mask, n_mask;
    logic [CFG_BITS-1:0] sat_bits;
    logic [AW:0]         mask_wide;

    // Saturate the window size and form the address mask
    always_comb begin
        priority if (i_cfg_data < CFG_BITS'(MIN_WINDOW_BITS)) begin
            sat_bits = CFG_BITS'(MIN_WINDOW_BITS);
        end else if (i_cfg_data > CFG_BITS'(AW)) begin
            sat_bits = CFG_BITS'(AW);
        end else begin
            sat_bits = i_cfg_data;
        end
        mask_wide = ((AW + 1)'(1) << sat_bits) - (AW + 1)'(1);
        n_mask    = mask_wide[AW-1:0];
    end

    assign o_cfg_ready = 1'b1;

    // Hold the window mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= RESET_MASK_WIDE[AW-1:0];
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask <= n_mask;
        end
    end

    ppbt_seq #(
        .MAX_WINDOW_BITS (MAX_WINDOW_BITS),
        .PAGE_SHIFT      (PAGE_SHIFT)
    ) u_seq (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_mask               (r_mask),
        .start                (start),
        .busy                 (busy),
        .i_func               (i_func),
        .i_guest_address      (i_guest_address),
        .i_byte_length        (i_byte_length),
        .o_done               (o_done),
        .o_mapped_bytes       (o_mapped_bytes),
        .o_whole_range_mapped (o_whole_range_mapped)
    );

    // A result follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without preceding work");

    // An accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but block not busy");

    // One strobe per transaction
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // A fully mapped probe reports at most 2^32 bytes
    a_whole_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_whole_range_mapped) |-> (o_mapped_bytes <= LEN_BITS'(1) << 32))
        else $error("mapped byte count out of range");

endmodule
